// ----- rtl/sha256_message_hasher_macros.svh -----
// ---------------------------------------------------------------------------
// SHA-256 message hasher assertion macros
// Shorthand for the clocked, reset-gated properties used at the top level.
// ---------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_HASHER_MACROS_SVH
`define SHA256_MESSAGE_HASHER_MACROS_SVH

// Same-cycle implication.
`define SMH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SMH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/smh_pkg.sv -----
// ---------------------------------------------------------------------------
// SHA-256 message hasher package
// Word types, queue entry type, hash constants and round functions.
// ---------------------------------------------------------------------------
package smh_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LENGTH_POS = 6'd56;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        end_of_message;
  } msg_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } dig_word_t;

  // Classified word as held in the queue: byte count already limited to 4.
  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        eom;
  } q_entry_t;

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] r;
    case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_const(input logic [5:0] i);
    logic [31:0] r;
    case (i)
      6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
      6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
      6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
      6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
      6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
      6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7; default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ----- rtl/smh_front.sv -----
// ---------------------------------------------------------------------------
// SHA-256 hasher front end
// Accepts message words, limits the byte count and queues them.
// ---------------------------------------------------------------------------
module smh_front
  import smh_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      msg_valid,
  output logic      msg_stall,
  input  msg_word_t msg,
  output logic      q_valid,
  input  logic      q_pop,
  output q_entry_t  q_head
);

  q_entry_t   mem [QDEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] fill;
  logic       push;
  logic       pop;
  q_entry_t   entry;

  // Counts of five to seven mean a full word.
  always_comb begin
    entry.data   = msg.data_word;
    entry.nbytes = (msg.byte_count > 3'd4) ? 3'd4 : msg.byte_count;
    entry.eom    = msg.end_of_message;
  end

  assign msg_stall = (fill == 3'(QDEPTH));
  assign push      = msg_valid && !msg_stall;
  assign q_valid   = (fill != 3'd0);
  assign pop       = q_pop && q_valid;
  assign q_head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= entry;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      fill <= fill + 3'(push) - 3'(pop);
    end
  end

endmodule

// ----- rtl/smh_back.sv -----
// ---------------------------------------------------------------------------
// SHA-256 hasher back end
// Packs bytes into the block, runs the rounds, pads and emits the digest.
// ---------------------------------------------------------------------------
module smh_back
  import smh_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  output logic      q_pop,
  input  q_entry_t  q_head,
  output logic      dig_valid,
  input  logic      dig_stall,
  output dig_word_t dig
);

  typedef enum logic [2:0] {
    S_IDLE, S_ABSORB, S_PAD, S_ROUND, S_UPDATE, S_OUT
  } state_t;

  typedef enum logic [1:0] {P_MARK, P_ZERO, P_LEN} pad_t;

  state_t      state;
  pad_t        pad_ph;
  logic [31:0] blk   [16];
  logic [31:0] chain [8];
  logic [31:0] v     [8];
  logic [5:0]  fill;
  logic [63:0] bitlen;
  logic [31:0] cur_data;
  logic [2:0]  cur_n;
  logic        cur_eom;
  logic [2:0]  bk;
  logic [2:0]  lk;
  logic        padding;
  logic        len_done;
  logic [5:0]  rnd;
  logic [2:0]  oi;

  logic        push;
  logic [7:0]  push_byte;
  logic [5:0]  fill_next;
  logic [31:0] w_next;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [7:0]  pad_byte;

  assign fill_next = fill + 6'd1;
  assign w_next = small_sig1(blk[14]) + blk[9] + small_sig0(blk[1]) + blk[0];
  assign t1 = v[7] + big_sig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
            + round_const(rnd) + blk[0];
  assign t2 = big_sig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  always_comb begin
    case (pad_ph)
      P_MARK:  pad_byte = PAD_MARK;
      P_ZERO:  pad_byte = 8'h00;
      P_LEN:   pad_byte = bitlen[{~lk, 3'b000} +: 8];
      default: pad_byte = 8'h00;
    endcase
  end

  always_comb begin
    push      = 1'b0;
    push_byte = pad_byte;
    if (state == S_ABSORB && bk != cur_n) begin
      push      = 1'b1;
      push_byte = cur_data[{~bk[1:0], 3'b000} +: 8];
    end else if (state == S_PAD) begin
      push = 1'b1;
    end
  end

  assign q_pop           = (state == S_IDLE);
  assign dig_valid       = (state == S_OUT);
  assign dig.digest_word = chain[oi];
  assign dig.word_index  = oi;
  assign dig.last_word   = (oi == 3'd7);

  always_ff @(posedge clk) begin
    if (push) begin
      blk[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= push_byte;
    end
    if (state == S_ROUND) begin
      for (int j = 0; j < 15; j++) begin
        blk[j] <= blk[j + 1];
      end
      blk[15] <= w_next;
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
    if (push && fill == 6'd63) begin
      for (int j = 0; j < 8; j++) begin
        v[j] <= chain[j];
      end
    end

    if (rst) begin
      state    <= S_IDLE;
      pad_ph   <= P_MARK;
      fill     <= '0;
      bitlen   <= '0;
      padding  <= 1'b0;
      len_done <= 1'b0;
      bk       <= '0;
      lk       <= '0;
      rnd      <= '0;
      oi       <= '0;
      for (int j = 0; j < 8; j++) begin
        chain[j] <= init_hash(3'(j));
      end
    end else begin
      if (push) begin
        fill <= fill_next;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur_data <= q_head.data;
            cur_n    <= q_head.nbytes;
            cur_eom  <= q_head.eom;
            bk       <= '0;
            state    <= S_ABSORB;
          end
        end
        S_ABSORB: begin
          if (bk != cur_n) begin
            bk     <= bk + 3'd1;
            bitlen <= bitlen + 64'd8;
            if (fill == 6'd63) begin
              rnd   <= '0;
              state <= S_ROUND;
            end
          end else if (cur_eom) begin
            padding <= 1'b1;
            pad_ph  <= P_MARK;
            lk      <= '0;
            state   <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_PAD: begin
          case (pad_ph)
            P_MARK, P_ZERO: begin
              if (fill_next == LENGTH_POS) begin
                pad_ph <= P_LEN;
              end else begin
                pad_ph <= P_ZERO;
              end
            end
            P_LEN: begin
              lk <= lk + 3'd1;
              if (lk == 3'd7) begin
                len_done <= 1'b1;
              end
            end
            default: pad_ph <= P_MARK;
          endcase
          if (fill == 6'd63) begin
            rnd   <= '0;
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          for (int j = 0; j < 8; j++) begin
            chain[j] <= chain[j] + v[j];
          end
          if (len_done) begin
            oi    <= '0;
            state <= S_OUT;
          end else if (padding) begin
            state <= S_PAD;
          end else begin
            state <= S_ABSORB;
          end
        end
        S_OUT: begin
          if (!dig_stall) begin
            oi <= oi + 3'd1;
            if (oi == 3'd7) begin
              for (int j = 0; j < 8; j++) begin
                chain[j] <= init_hash(3'(j));
              end
              fill     <= '0;
              bitlen   <= '0;
              padding  <= 1'b0;
              len_done <= 1'b0;
              state    <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/sha256_message_hasher.sv -----
// ---------------------------------------------------------------------------
// SHA-256 message hasher
// Hashes a byte message delivered as big-endian words; emits eight digest words.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake           Payload
//  msg      in         msg_valid/stall     data_word, byte_count, end_of_message
//  dig      out        dig_valid/stall     digest_word, word_index, last_word
//
// Each word is fetched from the queue, its valid bytes are packed into the
// block one after another by the byte packer, and the word is then closed.
// Each filled 64-byte block takes 64 rounds and one update of the chaining
// words on the single round unit.
// The final word is followed by its padding bytes and one or two compressions,
// then eight digest words leave one per unstalled cycle.
// Reset (rst, synchronous) loads the initial hash words and empties the queue.
// A stall on dig holds the back end; the four-word queue keeps taking input until it is full.
// ---------------------------------------------------------------------------
`include "sha256_message_hasher_macros.svh"

module sha256_message_hasher
  import smh_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      msg_valid,
  output logic      msg_stall,
  input  msg_word_t msg,
  output logic      dig_valid,
  input  logic      dig_stall,
  output dig_word_t dig
);

  // The queue between the two halves lets input keep arriving while the
  // round unit is busy or while digest words wait to be taken.
  logic     q_valid;
  logic     q_pop;
  q_entry_t q_head;

  smh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_head    (q_head)
  );

  // The back end walks bytes, rounds, padding and digest output in turn.
  smh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_head    (q_head),
    .dig_valid (dig_valid),
    .dig_stall (dig_stall),
    .dig       (dig)
  );

  // A delivered digest word that is not the last is followed by the next one.
  `SMH_ASSERT_NEXT(a_dig_seq, dig_valid && !dig_stall && !dig.last_word, dig_valid && dig.word_index == $past(dig.word_index) + 3'd1, "digest words out of order")
  // After the eighth word the digest run ends.
  `SMH_ASSERT_NEXT(a_dig_end, dig_valid && !dig_stall && dig.last_word, !dig_valid, "digest continues past last word")
  // The back end does not pull from the queue while digest words go out.
  `SMH_ASSERT_NOW(a_no_pop_while_out, dig_valid, !q_pop, "queue popped during digest output")

endmodule
